// ----- rtl/tgs_pkg.sv -----
// Shared types, codes and gain lookup for the timed gain scheduler.
package tgs_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_REFILL
  } tgs_state_e;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_CTRL = 1'b1;

  localparam logic [1:0] CODE_QPSK  = 2'd0;
  localparam logic [1:0] CODE_QAM16 = 2'd1;
  localparam logic [1:0] CODE_QAM64 = 2'd2;

  localparam logic [1:0] GAIN_ONE   = 2'd1;
  localparam logic [1:0] GAIN_TWO   = 2'd2;
  localparam logic [1:0] GAIN_THREE = 2'd3;

  localparam int unsigned TIME_W = 64;

  typedef struct packed {
    logic take;
    logic pop;
    logic emit;
  } tgs_cmd_t;

  typedef struct packed {
    logic pop_due;
    logic stall;
  } tgs_status_t;

  function automatic logic [1:0] code_to_gain(input logic [1:0] code);
    logic [1:0] g;
    unique case (code)
      CODE_QAM64: g = GAIN_THREE;
      CODE_QAM16: g = GAIN_TWO;
      default:    g = GAIN_ONE;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/tgs_ctrl.sv -----
// Controller state machine: request intake, queue pop sequencing, result issue.
module tgs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tuser_i,
  input  tgs_pkg::tgs_status_t status_i,
  output tgs_pkg::tgs_cmd_t    cmd_o,
  output logic                 s_axis_tready_o
);
  import tgs_pkg::*;

  tgs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.take = 1'b1;
          if (s_axis_tuser_i == REQ_DATA) begin
            state_d = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (status_i.pop_due) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_REFILL;
        end else if (!status_i.stall) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_REFILL: begin
        // head read data settles the cycle after the pointer moves
        state_d = ST_EVAL;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tgs_datapath.sv -----
// Datapath: change queue memory, sample counter, gain register, scaler, output register.
module tgs_datapath #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned IN_W         = 104,
  parameter int unsigned OUT_W        = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IN_W-1:0]      s_axis_tdata_i,
  input  logic                 s_axis_tuser_i,
  input  tgs_pkg::tgs_cmd_t    cmd_i,
  output tgs_pkg::tgs_status_t status_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OUT_W-1:0]     m_axis_tdata_o
);
  import tgs_pkg::*;

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned OW     = SAMPLE_WIDTH + 2;
  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W  = TIME_W + 2;
  localparam int unsigned PAD_W  = OUT_W - (2 * OW + 3);

  logic [SW-1:0]     in_si, in_sq;
  logic              in_tag;
  logic [1:0]        in_mcs;
  logic [TIME_W-1:0] in_at;

  assign in_si  = s_axis_tdata_i[SW-1:0];
  assign in_sq  = s_axis_tdata_i[2*SW-1:SW];
  assign in_tag = s_axis_tdata_i[2*SW];
  assign in_mcs = s_axis_tdata_i[2*SW+2:2*SW+1];
  assign in_at  = s_axis_tdata_i[2*SW+2+TIME_W:2*SW+3];

  logic [ENT_W-1:0]  mem_q [QUEUE_DEPTH];
  logic [ENT_W-1:0]  rd_q;
  logic [PTR_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              drop_q, drop_d;
  logic [TIME_W-1:0] count_q;
  logic [1:0]        gain_q, gain_d, gain_eff;
  logic [SW-1:0]     si_q, sq_q;
  logic              tag_q;
  logic [1:0]        mcs_q;
  logic              m_valid_q;
  logic [OW-1:0]     oi_q, oq_q;
  logic [1:0]        ogain_q;
  logic              odrop_q;
  logic              wr_en, full;
  logic [TIME_W-1:0] rd_time;
  logic [1:0]        rd_gain;
  logic [OW-1:0]     ext_i, ext_q, prod_i, prod_q;

  assign full    = (fill_q == FILL_W'(QUEUE_DEPTH));
  assign wr_en   = cmd_i.take && (s_axis_tuser_i == REQ_CTRL) && !full;
  assign rd_time = rd_q[ENT_W-1:2];
  assign rd_gain = rd_q[1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[tail_q] <= {in_at, code_to_gain(in_mcs)};
    end
    rd_q <= mem_q[head_q];
  end

  assign status_o.pop_due = (fill_q != '0) &&
                            ((rd_time == '0) || (rd_time <= count_q));
  assign status_o.stall   = m_valid_q && !m_axis_tready_i;

  assign gain_eff = tag_q ? code_to_gain(mcs_q) : gain_q;
  assign ext_i    = {{2{si_q[SW-1]}}, si_q};
  assign ext_q    = {{2{sq_q[SW-1]}}, sq_q};
  assign prod_i   = (gain_eff[0] ? ext_i : '0) +
                    (gain_eff[1] ? {ext_i[OW-2:0], 1'b0} : '0);
  assign prod_q   = (gain_eff[0] ? ext_q : '0) +
                    (gain_eff[1] ? {ext_q[OW-2:0], 1'b0} : '0);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    drop_d = drop_q;
    gain_d = gain_q;
    if (cmd_i.take && (s_axis_tuser_i == REQ_CTRL)) begin
      if (full) begin
        drop_d = 1'b1;
      end else begin
        tail_d = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
        fill_d = fill_q + 1'b1;
      end
    end
    if (cmd_i.pop) begin
      head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      fill_d = fill_q - 1'b1;
      gain_d = rd_gain;
    end
    if (cmd_i.emit) begin
      gain_d = gain_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      fill_q    <= '0;
      drop_q    <= 1'b0;
      gain_q    <= GAIN_ONE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      drop_q <= drop_d;
      gain_q <= gain_d;
      if (cmd_i.emit) begin
        count_q   <= count_q + 1'b1;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      si_q  <= in_si;
      sq_q  <= in_sq;
      tag_q <= in_tag;
      mcs_q <= in_mcs;
    end
    if (cmd_i.emit) begin
      oi_q    <= prod_i;
      oq_q    <= prod_q;
      ogain_q <= gain_eff;
      odrop_q <= drop_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, odrop_q, ogain_q, oq_q, oi_q};

endmodule

// ----- rtl/timed_gain_scheduler.sv -----
// Timed gain scheduler: top level joining controller and datapath.
//
// Input stream (s_axis): tuser selects the request kind, 0 data sample,
// 1 control message. A control message queues a gain change (from mcs_code)
// due at sample index due_time, 0 meaning as soon as possible; it is taken
// and yields no result. A full queue drops it and sets a sticky
// flag reported with every later result.
// A data sample is evaluated once no queue entry is due; each due entry is
// first popped from the queue head: each pop moves the head pointer and waits
// for the registered memory read of the new head before evaluating again.
// The result appears on m_axis in the output register the cycle after the
// sample is evaluated; the block accepts the next request while it waits.
// If the receiver stalls with a result still held, control messages and the
// next data sample are still taken; due entries for that sample are popped,
// but its result waits and no further request is taken until the output
// register frees.
// Reset clears the queue pointers, sample counter and sticky flag and sets
// the gain to one; queue contents are not cleared and need no clearing pass.
module timed_gain_scheduler #(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned SAMPLE_WIDTH = 16,
  localparam int unsigned IN_W  = ((2 * SAMPLE_WIDTH + 67 + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * SAMPLE_WIDTH + 7 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // sample_i, sample_q, tag_present, mcs_code[1:0], due_time[63:0], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  // req_type
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // out_i, out_q, gain_used[1:0], dropped_flag, zero pad
  output logic [OUT_W-1:0] m_axis_tdata
);
  import tgs_pkg::*;

  tgs_cmd_t    cmd;
  tgs_status_t status;

  tgs_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tuser_i  (s_axis_tuser),
    .status_i        (status),
    .cmd_o           (cmd),
    .s_axis_tready_o (s_axis_tready)
  );

  tgs_datapath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .IN_W         (IN_W),
    .OUT_W        (OUT_W)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .cmd_i           (cmd),
    .status_o        (status),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

// ----- rtl/tgs_checker.sv -----
// Port-level assertions for the timed gain scheduler and their bind.
module tgs_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned OUT_W        = 40
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);
  import tgs_pkg::*;

  localparam int unsigned OW     = SAMPLE_WIDTH + 2;
  localparam int unsigned GAIN_LO = 2 * OW;
  localparam int unsigned DROP_B  = 2 * OW + 2;

  logic [1:0] out_gain;
  logic       out_drop;
  logic       in_data_req;

  assign out_gain    = m_axis_tdata[GAIN_LO+1:GAIN_LO];
  assign out_drop    = m_axis_tdata[DROP_B];
  assign in_data_req = s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_DATA);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> out_gain != 2'd0)
    else $error("gain of zero reported");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && out_drop |=> !(m_axis_tvalid && !out_drop))
    else $error("drop flag cleared without reset");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_data_req |=> !s_axis_tready)
    else $error("request taken during sample evaluation");

endmodule

bind timed_gain_scheduler tgs_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH),
  .OUT_W        (OUT_W)
) u_tgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
